// File: rtl/core/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants, types and the rounded fixed-point multiply for the
// HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  localparam int IN_W   = 16;
  localparam int CH_W   = FRAC_BITS + 1;
  localparam int ONE_V  = 1 << FRAC_BITS;
  localparam int HALF_V = 1 << (FRAC_BITS - 1);

  localparam int SECTOR_COUNT = 6;
  localparam int SECTOR_U     = 60 << HUE_FRAC_BITS;
  localparam int FULL_U       = 360 << HUE_FRAC_BITS;

  // 360 degrees is 45 times a power of two, 60 degrees is 15 times one
  localparam int FULL_ODD = 45;
  localparam int SEC_ODD  = 15;

  localparam int IN_SPAN = 1 << (IN_W - 1);
  localparam int HUE_OFS = FULL_U * ((IN_SPAN + FULL_U - 1) / FULL_U);
  localparam int U_MAX   = IN_SPAN - 1 + HUE_OFS;
  localparam int U_W     = $clog2(U_MAX + 1);

  localparam int HW_SH = HUE_FRAC_BITS + 3;
  localparam int X_MAX = U_MAX >> HW_SH;
  localparam int X_W   = $clog2(X_MAX + 1);
  localparam int Q_MAX = U_MAX / FULL_U;
  localparam int Q_W   = $clog2(Q_MAX + 1);
  localparam int KH    = $clog2(X_MAX * FULL_ODD) + 1;
  localparam int MH    = ((1 << KH) + FULL_ODD - 1) / FULL_ODD;
  localparam int MH_W  = $clog2(MH + 1);
  localparam int PH_W  = X_W + MH_W + Q_W;

  localparam int HW_W  = $clog2(FULL_U);
  localparam int REM_W = $clog2(SECTOR_U);

  localparam int RS_SH = HUE_FRAC_BITS + 2;
  localparam int Y_W   = FRAC_BITS + 4;
  localparam int KF    = FRAC_BITS + 8;
  localparam int MF    = ((1 << KF) + SEC_ODD - 1) / SEC_ODD;
  localparam int MF_W  = $clog2(MF + 1);
  localparam int PF_W  = Y_W + MF_W;

  localparam int FRONT_DEPTH = 5;
  localparam int TERM_DEPTH  = 2;

  typedef logic signed [IN_W-1:0] sample_t;
  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [FRAC_BITS-1:0]   frac_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t sec;
    frac_t   f;
    chan_t   s;
    chan_t   v;
    sample_t alpha;
    logic    warn;
  } sector_item_t;

  typedef struct packed {
    sector_t sec;
    chan_t   v;
    chan_t   p;
    chan_t   q;
    chan_t   t;
    sample_t alpha;
    logic    warn;
  } term_item_t;

  function automatic chan_t fmul(chan_t a, chan_t b);
    logic [2*CH_W-1:0] prod;
    prod = {{CH_W{1'b0}}, a} * {{CH_W{1'b0}}, b} + (2*CH_W)'(HALF_V);
    return prod[FRAC_BITS +: CH_W];
  endfunction

endpackage

// File: rtl/core/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// hsvrgb_front
// Five-stage front end: clamp saturation and value, flag out-of-range
// inputs, wrap the hue by reciprocal multiply, find sector and fraction.
// ----------------------------------------------------------------------------
module hsvrgb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsvrgb_pkg::sample_t       hue,
  input  hsvrgb_pkg::sample_t       saturation,
  input  hsvrgb_pkg::sample_t       brightness,
  input  hsvrgb_pkg::sample_t       alpha_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsvrgb_pkg::sector_item_t  out_item
);
  import hsvrgb_pkg::*;

  typedef struct packed {
    chan_t   s;
    chan_t   v;
    sample_t alpha;
    logic    warn;
  } carry_t;

  function automatic chan_t clamp_unit(logic signed [31:0] x);
    chan_t res;
    if (x < 0) begin
      res = '0;
    end else if (x > ONE_V) begin
      res = CH_W'(ONE_V);
    end else begin
      res = CH_W'(x);
    end
    return res;
  endfunction

  logic [FRONT_DEPTH-1:0] vld_r, vld_nxt, adv;

  logic [U_W-1:0]   u1_r, u_nxt;
  carry_t           c1_r, c_nxt;
  logic [U_W-1:0]   u2_r;
  logic [Q_W-1:0]   q2_r, q_nxt;
  carry_t           c2_r;
  logic [HW_W-1:0]  hw3_r, hw_nxt;
  carry_t           c3_r;
  sector_t          sec4_r, sec_nxt;
  logic [REM_W-1:0] rem4_r, rem_nxt;
  carry_t           c4_r;
  sector_item_t     item5_r, item_nxt;

  logic signed [31:0]     h32, s32, v32;
  logic [X_W-1:0]         x_h;
  logic [PH_W-1:0]        prod_h;
  logic [U_W-1:0]         qfull;
  logic [HW_W-1:0]        base;
  logic [REM_W+FRAC_BITS-1:0] rsh;
  logic [Y_W-1:0]         y_f;
  logic [PF_W-1:0]        prod_f;

  always_comb begin
    adv[FRONT_DEPTH-1] = !vld_r[FRONT_DEPTH-1] || out_ready;
    for (int i = FRONT_DEPTH - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < FRONT_DEPTH; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_comb begin
    h32 = 32'(hue);
    s32 = 32'(saturation);
    v32 = 32'(brightness);
    c_nxt.warn  = (h32 < 0) || (h32 > FULL_U) || (s32 < 0) || (s32 > ONE_V) ||
                  (v32 < 0) || (v32 > ONE_V);
    c_nxt.s     = clamp_unit(s32);
    c_nxt.v     = clamp_unit(v32);
    c_nxt.alpha = alpha_in;
    u_nxt       = U_W'(h32 + HUE_OFS);
  end

  always_comb begin
    x_h    = X_W'(u1_r >> HW_SH);
    prod_h = PH_W'(x_h) * PH_W'(MH);
    q_nxt  = prod_h[KH +: Q_W];
  end

  always_comb begin
    qfull  = U_W'(32'(q2_r) * FULL_U);
    hw_nxt = HW_W'(u2_r - qfull);
  end

  always_comb begin
    sec_nxt = SEC_RY;
    base    = '0;
    for (int k = 1; k < SECTOR_COUNT; k++) begin
      if (hw3_r >= HW_W'(k * SECTOR_U)) begin
        sec_nxt = sector_t'(k);
        base    = HW_W'(k * SECTOR_U);
      end
    end
    rem_nxt = REM_W'(hw3_r - base);
  end

  always_comb begin
    rsh            = {rem4_r, {FRAC_BITS{1'b0}}};
    y_f            = Y_W'(rsh >> RS_SH);
    prod_f         = PF_W'(y_f) * PF_W'(MF);
    item_nxt.sec   = sec4_r;
    item_nxt.f     = prod_f[KF +: FRAC_BITS];
    item_nxt.s     = c4_r.s;
    item_nxt.v     = c4_r.v;
    item_nxt.alpha = c4_r.alpha;
    item_nxt.warn  = c4_r.warn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u1_r <= u_nxt;
      c1_r <= c_nxt;
    end
    if (adv[1]) begin
      u2_r <= u1_r;
      q2_r <= q_nxt;
      c2_r <= c1_r;
    end
    if (adv[2]) begin
      hw3_r <= hw_nxt;
      c3_r  <= c2_r;
    end
    if (adv[3]) begin
      sec4_r <= sec_nxt;
      rem4_r <= rem_nxt;
      c4_r   <= c3_r;
    end
    if (adv[4]) begin
      item5_r <= item_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[FRONT_DEPTH-1];
  assign out_item  = item5_r;

endmodule

// File: rtl/core/hsvrgb_terms.sv
// ----------------------------------------------------------------------------
// hsvrgb_terms
// Two-stage multiply section: form f*s, (1-f)*s and p, then q and t.
// ----------------------------------------------------------------------------
module hsvrgb_terms (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsvrgb_pkg::sector_item_t  in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsvrgb_pkg::term_item_t    out_item
);
  import hsvrgb_pkg::*;

  logic [TERM_DEPTH-1:0] vld_r, vld_nxt, adv;

  sector_t    sec1_r;
  chan_t      v1_r, p1_r, fs1_r, fns1_r;
  chan_t      p_nxt, fs_nxt, fns_nxt;
  sample_t    a1_r;
  logic       w1_r;
  term_item_t item2_r, item_nxt;
  chan_t      one_c, f_c;

  always_comb begin
    adv[TERM_DEPTH-1] = !vld_r[TERM_DEPTH-1] || out_ready;
    for (int i = TERM_DEPTH - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < TERM_DEPTH; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_comb begin
    one_c   = CH_W'(ONE_V);
    f_c     = {1'b0, in_item.f};
    p_nxt   = fmul(in_item.v, one_c - in_item.s);
    fs_nxt  = fmul(f_c, in_item.s);
    fns_nxt = fmul(one_c - f_c, in_item.s);
  end

  always_comb begin
    item_nxt.sec   = sec1_r;
    item_nxt.v     = v1_r;
    item_nxt.p     = p1_r;
    item_nxt.q     = fmul(v1_r, one_c - fs1_r);
    item_nxt.t     = fmul(v1_r, one_c - fns1_r);
    item_nxt.alpha = a1_r;
    item_nxt.warn  = w1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec1_r <= in_item.sec;
      v1_r   <= in_item.v;
      p1_r   <= p_nxt;
      fs1_r  <= fs_nxt;
      fns1_r <= fns_nxt;
      a1_r   <= in_item.alpha;
      w1_r   <= in_item.warn;
    end
    if (adv[1]) begin
      item2_r <= item_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[TERM_DEPTH-1];
  assign out_item  = item2_r;

endmodule

// File: rtl/core/hsv_to_rgb_converter.sv
// Throughput: one request per cycle while the output is not stalled by
// out_ready; the hue wrap, sector search, fraction reciprocal and the two
// rounds of multiplies each hold their own stage.
// Reset: synchronous active-low rst_n clears all stage valid bits; data
// registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to RGB conversion with alpha pass-through and a range
// warning flag. Front end, multiply section and a registered channel select.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvrgb_pkg::sample_t  in_hue,
  input  hsvrgb_pkg::sample_t  in_saturation,
  input  hsvrgb_pkg::sample_t  in_brightness,
  input  hsvrgb_pkg::sample_t  in_alpha_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvrgb_pkg::chan_t    out_red,
  output hsvrgb_pkg::chan_t    out_green,
  output hsvrgb_pkg::chan_t    out_blue,
  output hsvrgb_pkg::sample_t  out_alpha_out,
  output logic                 out_range_warning
);
  import hsvrgb_pkg::*;

  logic         fr_valid, fr_ready;
  sector_item_t fr_item;
  logic         tm_valid, tm_ready;
  term_item_t   tm_item;

  logic    valid_r, valid_nxt, adv;
  chan_t   red_r, green_r, blue_r;
  chan_t   red_nxt, green_nxt, blue_nxt;
  sample_t alpha_r;
  logic    warn_r;

  hsvrgb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .alpha_in   (in_alpha_in),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_item   (fr_item)
  );

  hsvrgb_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (tm_valid),
    .out_ready (tm_ready),
    .out_item  (tm_item)
  );

  assign adv       = !valid_r || out_ready;
  assign tm_ready  = adv;
  assign valid_nxt = adv ? tm_valid : valid_r;

  always_comb begin
    case (tm_item.sec)
      SEC_RY: begin
        red_nxt = tm_item.v; green_nxt = tm_item.t; blue_nxt = tm_item.p;
      end
      SEC_YG: begin
        red_nxt = tm_item.q; green_nxt = tm_item.v; blue_nxt = tm_item.p;
      end
      SEC_GC: begin
        red_nxt = tm_item.p; green_nxt = tm_item.v; blue_nxt = tm_item.t;
      end
      SEC_CB: begin
        red_nxt = tm_item.p; green_nxt = tm_item.q; blue_nxt = tm_item.v;
      end
      SEC_BM: begin
        red_nxt = tm_item.t; green_nxt = tm_item.p; blue_nxt = tm_item.v;
      end
      default: begin
        red_nxt = tm_item.v; green_nxt = tm_item.p; blue_nxt = tm_item.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= tm_item.alpha;
      warn_r  <= tm_item.warn;
    end
  end

  assign out_valid         = valid_r;
  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_alpha_out     = alpha_r;
  assign out_range_warning = warn_r;

`ifndef SYNTH
  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= CH_W'(ONE_V)) && (out_green <= CH_W'(ONE_V)) &&
                  (out_blue <= CH_W'(ONE_V)))
    else $error("channel above full scale");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output not blocked");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
